[hw/rtl/ogp_pkg.sv]
`default_nettype none
package ogp_pkg;

	localparam int CORDIC_STAGES = 18;

	localparam int DEG_W = 27;
	localparam int ANG_W = 32;
	localparam int XY_W = 34;
	localparam int ZM_W = 29;
	localparam int DIM_W = 14;
	localparam int TX_W = 40;
	localparam int POS_W = 56;
	localparam int LAT_W = 24;
	localparam int LON_W = 25;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 29;

	localparam logic signed [DEG_W-1:0] DEG90_Q16 = 27'sd5898240;
	localparam logic signed [DEG_W-1:0] DEG180_Q16 = 27'sd11796480;
	localparam logic signed [DEG_W-1:0] DEG360_Q16 = 27'sd23592960;
	localparam logic signed [LAT_W-1:0] LAT_LIMIT_Q16 = 24'sd5898240;
	localparam logic signed [XY_W-1:0] GAIN_Q30 = 34'sd652032874;
	localparam logic [ZM_W-1:0] ZOOM_MIN = 29'd13107;
	localparam logic [ZM_W-1:0] ZOOM_MAX = 29'd327680000;
	localparam longint RAD_Q24 = 64'sd961263669;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_LON = 3'd0,
		REG_CENTER_LAT = 3'd1,
		REG_BEARING    = 3'd2,
		REG_ZOOM       = 3'd3,
		REG_WIDTH      = 3'd4,
		REG_HEIGHT     = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [ANG_W-1:0] ang;
		logic                    neg;
	} ang_t;

	typedef struct packed {
		logic signed [XY_W-1:0] sin;
		logic signed [XY_W-1:0] cos;
	} trig_t;

	typedef struct packed {
		logic [ZM_W-1:0]  zoom;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} view_cfg_t;

	typedef struct packed {
		logic vld;
		logic ok;
	} ctl_t;

	function automatic logic signed [ANG_W-1:0] step_angle(input int i);
		longint a;
		case (i)
			0: a = 64'sd754974720;
			1: a = 64'sd445687602;
			2: a = 64'sd235489088;
			3: a = 64'sd119537938;
			4: a = 64'sd60000934;
			5: a = 64'sd30029717;
			6: a = 64'sd15018523;
			7: a = 64'sd7509720;
			8: a = 64'sd3754917;
			9: a = 64'sd1877466;
			default: a = (RAD_Q24 + (64'sd1 <<< (i - 1))) >>> i;
		endcase
		return ANG_W'(a);
	endfunction

	function automatic logic signed [XY_W-1:0] mul30(input logic signed [XY_W-1:0] a,
		input logic signed [XY_W-1:0] b);
		logic signed [2*XY_W-1:0] p;
		p = a * b + (2*XY_W)'(64'sd536870912);
		return XY_W'(p >>> 30);
	endfunction

endpackage
`default_nettype wire

[hw/rtl/orthographic_globe_projection.sv]
// A point accepted while start is high gives its result word with done high once it has
// passed the input register, the angle preparation, the CORDIC and the projection stages.
// Throughput: one point per cycle; busy stays low, set by the fully pipelined CORDICs.
// The receiver cannot stall, so every result word is shown for exactly one cycle.
// Reset is asynchronous and active low; it empties the pipeline and restores the
// default configuration.
`default_nettype none
module orthographic_globe_projection (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic signed [ogp_pkg::LON_W-1:0]       point_longitude,
	input  wire logic signed [ogp_pkg::LAT_W-1:0]       point_latitude,
	output logic                                        done,
	output logic                                        ok,
	output logic                                        on_view,
	output logic signed [31:0]                          screen_x,
	output logic signed [31:0]                          screen_y,
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [ogp_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [ogp_pkg::CFG_DATA_W-1:0]         cfg_data
);

	localparam int DEG_W = ogp_pkg::DEG_W;
	localparam int CHAIN = ogp_pkg::CORDIC_STAGES + 3;
	localparam int LATENCY = ogp_pkg::CORDIC_STAGES + 10;

	logic signed [ogp_pkg::LON_W-1:0] clon_q;
	logic signed [ogp_pkg::LAT_W-1:0] clat_q;
	logic signed [ogp_pkg::LON_W-1:0] bear_q;
	logic [ogp_pkg::ZM_W-1:0]         zoom_q;
	logic [ogp_pkg::DIM_W-1:0]        width_q;
	logic [ogp_pkg::DIM_W-1:0]        height_q;

	logic signed [ogp_pkg::LAT_W-1:0] clat_c;
	logic signed [ogp_pkg::LAT_W-1:0] lat_s1;
	logic signed [DEG_W-1:0]          dlon_s1;
	ogp_pkg::ctl_t                    ctl_s1;
	ogp_pkg::ctl_t                    ctl_pipe [CHAIN];
	logic                             accept;
	logic                             pt_ok;

	ogp_pkg::ang_t    a_lat, a_clat, a_dlon, a_bear;
	ogp_pkg::trig_t   t_lat, t_clat, t_dlon, t_bear;
	ogp_pkg::view_cfg_t view;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clon_q   <= '0;
			clat_q   <= '0;
			bear_q   <= '0;
			zoom_q   <= 29'd65536;
			width_q  <= 14'd1;
			height_q <= 14'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (ogp_pkg::cfg_reg_t'(cfg_index))
				ogp_pkg::REG_CENTER_LON: clon_q <= cfg_data[ogp_pkg::LON_W-1:0];
				ogp_pkg::REG_CENTER_LAT: clat_q <= cfg_data[ogp_pkg::LAT_W-1:0];
				ogp_pkg::REG_BEARING:    bear_q <= cfg_data[ogp_pkg::LON_W-1:0];
				ogp_pkg::REG_ZOOM:       zoom_q <= cfg_data[ogp_pkg::ZM_W-1:0];
				ogp_pkg::REG_WIDTH:      width_q <= cfg_data[ogp_pkg::DIM_W-1:0];
				ogp_pkg::REG_HEIGHT:     height_q <= cfg_data[ogp_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (clat_q > ogp_pkg::LAT_LIMIT_Q16) begin
			clat_c = ogp_pkg::LAT_LIMIT_Q16;
		end else if (clat_q < -ogp_pkg::LAT_LIMIT_Q16) begin
			clat_c = -ogp_pkg::LAT_LIMIT_Q16;
		end else begin
			clat_c = clat_q;
		end
		pt_ok = point_latitude >= -ogp_pkg::LAT_LIMIT_Q16 &&
			point_latitude <= ogp_pkg::LAT_LIMIT_Q16 &&
			width_q != '0 && height_q != '0;
		view.zoom   = zoom_q;
		view.width  = width_q;
		view.height = height_q;
	end

	always_ff @(posedge clk) begin
		lat_s1  <= point_latitude;
		dlon_s1 <= DEG_W'(point_longitude) - DEG_W'(clon_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			for (int i = 0; i < CHAIN; i++) begin
				ctl_pipe[i] <= '0;
			end
		end else begin
			ctl_s1.vld  <= accept;
			ctl_s1.ok   <= accept && pt_ok;
			ctl_pipe[0] <= ctl_s1;
			for (int i = 1; i < CHAIN; i++) begin
				ctl_pipe[i] <= ctl_pipe[i-1];
			end
		end
	end

	ogp_angle_prep u_prep_lat  (.clk(clk), .deg(DEG_W'(lat_s1)), .angle(a_lat));
	ogp_angle_prep u_prep_clat (.clk(clk), .deg(DEG_W'(clat_c)), .angle(a_clat));
	ogp_angle_prep u_prep_dlon (.clk(clk), .deg(dlon_s1),        .angle(a_dlon));
	ogp_angle_prep u_prep_bear (.clk(clk), .deg(DEG_W'(bear_q)), .angle(a_bear));

	ogp_cordic u_cordic_lat  (.clk(clk), .angle(a_lat),  .trig(t_lat));
	ogp_cordic u_cordic_clat (.clk(clk), .angle(a_clat), .trig(t_clat));
	ogp_cordic u_cordic_dlon (.clk(clk), .angle(a_dlon), .trig(t_dlon));
	ogp_cordic u_cordic_bear (.clk(clk), .angle(a_bear), .trig(t_bear));

	ogp_project u_project (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   (ctl_pipe[CHAIN-1]),
		.lat      (t_lat),
		.clat     (t_clat),
		.dlon     (t_dlon),
		.bear     (t_bear),
		.view     (view),
		.done     (done),
		.ok       (ok),
		.on_view  (on_view),
		.screen_x (screen_x),
		.screen_y (screen_y)
	);

	ap_latency : assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("result word missing after pipeline latency");
	ap_bad_lat : assert property (@(posedge clk) disable iff (!arst_n)
		accept && (point_latitude > ogp_pkg::LAT_LIMIT_Q16 ||
			point_latitude < -ogp_pkg::LAT_LIMIT_Q16) |-> ##LATENCY !ok)
		else $error("out of range latitude reported as valid");
	ap_no_spurious : assert property (@(posedge clk) disable iff (!arst_n)
		!accept |-> ##LATENCY !done)
		else $error("result word without an accepted point");

endmodule
`default_nettype wire

[hw/rtl/ogp_angle_prep.sv]
`default_nettype none
module ogp_angle_prep (
	input  wire logic                                  clk,
	input  wire logic signed [ogp_pkg::DEG_W-1:0]      deg,
	output ogp_pkg::ang_t                              angle
);

	logic signed [ogp_pkg::DEG_W-1:0] red;
	logic signed [ogp_pkg::DEG_W-1:0] red_s1;
	logic signed [ogp_pkg::DEG_W-1:0] fold;
	logic                             neg;

	always_comb begin
		if (deg >= ogp_pkg::DEG180_Q16) begin
			red = deg - ogp_pkg::DEG360_Q16;
		end else if (deg < -ogp_pkg::DEG180_Q16) begin
			red = deg + ogp_pkg::DEG360_Q16;
		end else begin
			red = deg;
		end
	end

	always_comb begin
		if (red_s1 > ogp_pkg::DEG90_Q16) begin
			fold = red_s1 - ogp_pkg::DEG180_Q16;
			neg  = 1'b1;
		end else if (red_s1 < -ogp_pkg::DEG90_Q16) begin
			fold = red_s1 + ogp_pkg::DEG180_Q16;
			neg  = 1'b1;
		end else begin
			fold = red_s1;
			neg  = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		red_s1    <= red;
		angle.ang <= ogp_pkg::ANG_W'(fold) <<< 8;
		angle.neg <= neg;
	end

endmodule
`default_nettype wire

[hw/rtl/ogp_cordic.sv]
`default_nettype none
module ogp_cordic (
	input  wire logic   clk,
	input  ogp_pkg::ang_t angle,
	output ogp_pkg::trig_t trig
);

	logic signed [ogp_pkg::XY_W-1:0]  x_s [ogp_pkg::CORDIC_STAGES+1];
	logic signed [ogp_pkg::XY_W-1:0]  y_s [ogp_pkg::CORDIC_STAGES+1];
	logic signed [ogp_pkg::ANG_W-1:0] r_s [ogp_pkg::CORDIC_STAGES];
	logic                             neg_s [ogp_pkg::CORDIC_STAGES+1];

	assign x_s[0]   = ogp_pkg::GAIN_Q30;
	assign y_s[0]   = '0;
	assign r_s[0]   = angle.ang;
	assign neg_s[0] = angle.neg;

	for (genvar i = 0; i < ogp_pkg::CORDIC_STAGES; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (!r_s[i][ogp_pkg::ANG_W-1]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
			end
			neg_s[i+1] <= neg_s[i];
		end
		if (i < ogp_pkg::CORDIC_STAGES - 1) begin : g_angle
			localparam logic signed [ogp_pkg::ANG_W-1:0] STEP = ogp_pkg::step_angle(i);
			always_ff @(posedge clk) begin
				if (!r_s[i][ogp_pkg::ANG_W-1]) begin
					r_s[i+1] <= r_s[i] - STEP;
				end else begin
					r_s[i+1] <= r_s[i] + STEP;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (neg_s[ogp_pkg::CORDIC_STAGES]) begin
			trig.sin <= -y_s[ogp_pkg::CORDIC_STAGES];
			trig.cos <= -x_s[ogp_pkg::CORDIC_STAGES];
		end else begin
			trig.sin <= y_s[ogp_pkg::CORDIC_STAGES];
			trig.cos <= x_s[ogp_pkg::CORDIC_STAGES];
		end
	end

endmodule
`default_nettype wire

[hw/rtl/ogp_project.sv]
`default_nettype none
module ogp_project (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  ogp_pkg::ctl_t           ctl_in,
	input  ogp_pkg::trig_t          lat,
	input  ogp_pkg::trig_t          clat,
	input  ogp_pkg::trig_t          dlon,
	input  ogp_pkg::trig_t          bear,
	input  ogp_pkg::view_cfg_t      view,
	output logic                    done,
	output logic                    ok,
	output logic                    on_view,
	output logic signed [31:0]      screen_x,
	output logic signed [31:0]      screen_y
);

	localparam int XY_W = ogp_pkg::XY_W;
	localparam int TX_W = ogp_pkg::TX_W;
	localparam int POS_W = ogp_pkg::POS_W;
	localparam int DIM_W = ogp_pkg::DIM_W;
	localparam int ZM_W = ogp_pkg::ZM_W;

	ogp_pkg::ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;

	logic signed [XY_W-1:0] ccd_s1, x_s1, ccsl_s1, scsl_s1, sc_s1, cc_s1, sb_s1, cb_s1;
	logic signed [XY_W-1:0] y_s2, x_s2, sb_s2, cb_s2;
	logic signed [XY_W-1:0] z;
	logic                   zneg_s2, zneg_s3, zneg_s4, zneg_s5;
	logic signed [XY_W-1:0] vx_s3, vy_s3;
	logic signed [TX_W-1:0] tx_s4, ty_s4;
	logic signed [POS_W-1:0] px_s5, py_s5;

	logic [ZM_W-1:0]               zoom_c;
	logic signed [XY_W+ZM_W:0]     zx, zy;
	logic [DIM_W-1:0]              m;
	logic signed [TX_W+DIM_W:0]    mx, my;
	logic signed [POS_W-1:0]       wq, hq, wlim, hlim;
	logic                          vis;

	function automatic logic signed [31:0] sat_screen(input logic signed [POS_W-1:0] v);
		logic signed [POS_W-1:0] q;
		q = (v + POS_W'(64'sd524288)) >>> 20;
		if (q > POS_W'(64'sd2147483647)) begin
			return 32'sh7fffffff;
		end else if (q < -POS_W'(64'sd2147483648)) begin
			return 32'sh80000000;
		end
		return q[31:0];
	endfunction

	always_comb begin
		if (view.zoom < ogp_pkg::ZOOM_MIN) begin
			zoom_c = ogp_pkg::ZOOM_MIN;
		end else if (view.zoom > ogp_pkg::ZOOM_MAX) begin
			zoom_c = ogp_pkg::ZOOM_MAX;
		end else begin
			zoom_c = view.zoom;
		end
		m    = (view.width < view.height) ? view.width : view.height;
		zx   = vx_s3 * $signed({1'b0, zoom_c}) + (XY_W+ZM_W+1)'(64'sd33554432);
		zy   = vy_s3 * $signed({1'b0, zoom_c}) + (XY_W+ZM_W+1)'(64'sd33554432);
		mx   = tx_s4 * $signed({1'b0, m});
		my   = ty_s4 * $signed({1'b0, m});
		wq   = POS_W'($signed({1'b0, view.width})) <<< 23;
		hq   = POS_W'($signed({1'b0, view.height})) <<< 23;
		wlim = POS_W'($signed({1'b0, view.width})) <<< 24;
		hlim = POS_W'($signed({1'b0, view.height})) <<< 24;
		z    = scsl_s1 + ogp_pkg::mul30(cc_s1, ccd_s1);
		vis  = !zneg_s5 && !px_s5[POS_W-1] && px_s5 <= wlim && !py_s5[POS_W-1] && py_s5 <= hlim;
	end

	always_ff @(posedge clk) begin
		ccd_s1  <= ogp_pkg::mul30(lat.cos, dlon.cos);
		x_s1    <= ogp_pkg::mul30(lat.cos, dlon.sin);
		ccsl_s1 <= ogp_pkg::mul30(clat.cos, lat.sin);
		scsl_s1 <= ogp_pkg::mul30(clat.sin, lat.sin);
		sc_s1   <= clat.sin;
		cc_s1   <= clat.cos;
		sb_s1   <= bear.sin;
		cb_s1   <= bear.cos;

		y_s2    <= ccsl_s1 - ogp_pkg::mul30(sc_s1, ccd_s1);
		zneg_s2 <= z[XY_W-1];
		x_s2    <= x_s1;
		sb_s2   <= sb_s1;
		cb_s2   <= cb_s1;

		vx_s3   <= ogp_pkg::mul30(x_s2, cb_s2) - ogp_pkg::mul30(y_s2, sb_s2);
		vy_s3   <= ogp_pkg::mul30(x_s2, sb_s2) + ogp_pkg::mul30(y_s2, cb_s2);
		zneg_s3 <= zneg_s2;

		tx_s4   <= TX_W'(zx >>> 26);
		ty_s4   <= TX_W'(zy >>> 26);
		zneg_s4 <= zneg_s3;

		px_s5   <= wq + (POS_W'(mx) <<< 3);
		py_s5   <= hq - (POS_W'(my) <<< 3);
		zneg_s5 <= zneg_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1   <= '0;
			ctl_s2   <= '0;
			ctl_s3   <= '0;
			ctl_s4   <= '0;
			ctl_s5   <= '0;
			done     <= 1'b0;
			ok       <= 1'b0;
			on_view  <= 1'b0;
			screen_x <= '0;
			screen_y <= '0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			done   <= ctl_s5.vld;
			ok     <= ctl_s5.ok;
			if (ctl_s5.ok) begin
				on_view  <= vis;
				screen_x <= sat_screen(px_s5);
				screen_y <= sat_screen(py_s5);
			end else begin
				on_view  <= 1'b0;
				screen_x <= '0;
				screen_y <= '0;
			end
		end
	end

	ap_on_view_ok : assert property (@(posedge clk) disable iff (!arst_n)
		on_view |-> ok)
		else $error("on_view without ok");
	ap_zero_invalid : assert property (@(posedge clk) disable iff (!arst_n)
		!ok |-> screen_x == 0 && screen_y == 0)
		else $error("invalid word with nonzero position");
	ap_ok_done : assert property (@(posedge clk) disable iff (!arst_n)
		ok |-> done)
		else $error("ok outside a result word");

endmodule
`default_nettype wire
